@@ sv/xsb_pkg.sv @@
// xsb_pkg: types and constants shared by the xor sprite blit address and mask unit
package xsb_pkg;

  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } xsb_pos_t;

  typedef struct packed {
    logic [15:0] write_address;
    logic [7:0]  xor_mask;
    logic        last;
  } xsb_wr_t;

  typedef struct packed {
    logic load;
    logic emit;
  } xsb_cmd_t;

  typedef struct packed {
    logic offset_zero;
    logic final_row;
    logic second_half;
    logic out_blocked;
  } xsb_status_t;

  localparam logic       REG_SCREEN_BASE    = 1'b0;
  localparam logic       REG_SPRITE_PATTERN = 1'b1;

  localparam logic [15:0] BASE_RESET     = 16'h2000;
  localparam logic [63:0] PATTERN_RESET  = 64'h7EC3_81DB_7E99_42E7;
  localparam logic [15:0] CELL_ROW_STEP  = 16'd312;
  localparam logic [15:0] SPILL_DISTANCE = 16'd8;

endpackage

@@ sv/xor_sprite_blit_address_mask_unit.sv @@
// xor_sprite_blit_address_mask_unit: top level of the xor sprite blit address generator
//
// A sprite position beat (pos_x, pos_y) on the pos channel starts one blit; the
// unit then sends the bitmap writes on the wr channel, each an address and an
// xor mask for a read-modify-write downstream. last marks the final beat.
// There are 8 write beats when pos_x mod 8 is zero, otherwise 16: for each row
// the shifted byte, then its spill 8 bytes further on.
// The first write beat enters the output register after the sequencer moves to its run state, and
// the rest follow one per cycle from the sequencer while wr is not stalled.
// pos_stall stays high from acceptance until the last beat is loaded into the
// output register, so the sequencer runs one blit at a time.
// A stall on wr holds the output register and pauses the sequencer.
// Configuration (screen_base, sprite_pattern) is written through cfg_write, cfg_index
// and cfg_data, by the user only while the unit is idle; the unit does not enforce this.
// Reset is synchronous: the sequencer goes idle, the output is emptied and the
// registers take their defaults (base 0x2000, built-in sprite pattern).
module xor_sprite_blit_address_mask_unit
  import xsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pos_valid,
  output logic        pos_stall,
  input  xsb_pos_t    pos,
  output logic        wr_valid,
  input  logic        wr_stall,
  output xsb_wr_t     wr,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  xsb_cmd_t    cmd;
  xsb_status_t status;

  xsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pos_valid (pos_valid),
    .pos_stall (pos_stall),
    .status    (status),
    .cmd       (cmd)
  );

  xsb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos       (pos),
    .cmd       (cmd),
    .status    (status),
    .wr_valid  (wr_valid),
    .wr_stall  (wr_stall),
    .wr        (wr)
  );

endmodule

@@ sv/xsb_ctrl.sv @@
// xsb_ctrl: sequencer state machine for the sprite write beats
module xsb_ctrl
  import xsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pos_valid,
  output logic        pos_stall,
  input  xsb_status_t status,
  output xsb_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic last_beat;

  assign last_beat = status.final_row && (status.second_half || status.offset_zero);

  always_comb begin
    cmd.load   = (state == ST_IDLE) && pos_valid;
    cmd.emit   = (state == ST_RUN) && !status.out_blocked;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pos_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.emit && last_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign pos_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/xsb_datapath.sv @@
// xsb_datapath: configuration registers, row address stepping and output register
module xsb_datapath
  import xsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  xsb_pos_t    pos,
  input  xsb_cmd_t    cmd,
  output xsb_status_t status,
  output logic        wr_valid,
  input  logic        wr_stall,
  output xsb_wr_t     wr
);

  logic [15:0] screen_base;
  logic [63:0] sprite_pattern;
  logic [15:0] row_address;
  logic [15:0] row_address_next;
  logic [2:0]  row_index;
  logic [2:0]  row_index_next;
  logic        second_half;
  logic [2:0]  bit_offset;
  logic [2:0]  y_low;
  logic [15:0] start_address;
  logic [7:0]  row_data;
  logic [15:0] shifted;
  logic        crossing;
  logic        final_row;

  assign start_address = screen_base
                       + {13'd0, pos.pos_y[2:0]}
                       + {8'd0, pos.pos_x[7:3], 3'd0}
                       + {3'd0, pos.pos_y[7:3], 8'd0}
                       + {5'd0, pos.pos_y[7:3], 6'd0};

  assign row_data  = sprite_pattern[6'd63 - {row_index, 3'd0} -: 8];
  assign shifted   = {row_data, 8'd0} >> bit_offset;
  assign final_row = (row_index == 3'd7);

  // next row enters the next cell row
  assign row_index_next   = row_index + 3'd1;
  assign crossing         = (y_low != 3'd0) && (row_index_next == (3'd0 - y_low));
  assign row_address_next = row_address + 16'd1 + (crossing ? CELL_ROW_STEP : 16'd0);

  assign status.offset_zero = (bit_offset == 3'd0);
  assign status.final_row   = final_row;
  assign status.second_half = second_half;
  assign status.out_blocked = wr_valid && wr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_base    <= BASE_RESET;
      sprite_pattern <= PATTERN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_BASE:    screen_base    <= cfg_data[15:0];
        REG_SPRITE_PATTERN: sprite_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= 3'd0;
      second_half <= 1'b0;
      wr_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        row_index   <= 3'd0;
        second_half <= 1'b0;
      end else if (cmd.emit) begin
        if (!second_half && (bit_offset != 3'd0)) begin
          second_half <= 1'b1;
        end else begin
          second_half <= 1'b0;
          row_index   <= row_index_next;
        end
      end
      if (cmd.emit) begin
        wr_valid <= 1'b1;
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_address <= start_address;
      bit_offset  <= pos.pos_x[2:0];
      y_low       <= pos.pos_y[2:0];
    end else if (cmd.emit && (second_half || (bit_offset == 3'd0))) begin
      row_address <= row_address_next;
    end
    if (cmd.emit) begin
      wr.write_address <= second_half ? (row_address + SPILL_DISTANCE) : row_address;
      wr.xor_mask      <= second_half ? shifted[7:0] : shifted[15:8];
      wr.last          <= final_row && (second_half || (bit_offset == 3'd0));
    end
  end

endmodule

@@ tb/xor_sprite_blit_address_mask_unit_tb.sv @@
// xor_sprite_blit_address_mask_unit_tb: self-checking testbench for the xor sprite blit unit
module xor_sprite_blit_address_mask_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xsb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  class blit_scoreboard;
    logic [15:0] screen_base;
    logic [63:0] sprite_pattern;
    xsb_wr_t     expected_writes[$];
    int          errors;

    function new();
      screen_base    = BASE_RESET;
      sprite_pattern = PATTERN_RESET;
      errors         = 0;
    endfunction

    function void set_reg(logic idx, logic [63:0] value);
      if (idx == REG_SCREEN_BASE) begin
        screen_base = value[15:0];
      end else if (idx == REG_SPRITE_PATTERN) begin
        sprite_pattern = value;
      end
    endfunction

    function void add_sprite(xsb_pos_t p);
      logic [2:0]  shift;
      logic [15:0] addr;
      logic [7:0]  row_byte;
      logic [7:0]  spill;
      xsb_wr_t     w;
      int          rows_first;
      shift      = p.pos_x[2:0];
      addr       = screen_base + 16'(p.pos_y[2:0]) + 16'(p.pos_x[7:3]) * 16'd8
                   + 16'(p.pos_y[7:3]) * 16'd320;
      rows_first = 8 - int'(p.pos_y[2:0]);
      for (int r = 0; r < 8; r++) begin
        row_byte = sprite_pattern[63 - 8 * r -: 8];
        if (r == rows_first) begin
          addr = addr + CELL_ROW_STEP;
        end
        w.write_address = addr;
        w.xor_mask      = row_byte >> shift;
        w.last          = (r == 7) && (shift == 3'd0);
        expected_writes.push_back(w);
        if (shift != 3'd0) begin
          spill           = row_byte << (4'd8 - 4'(shift));
          w.write_address = addr + SPILL_DISTANCE;
          w.xor_mask      = spill;
          w.last          = (r == 7);
          expected_writes.push_back(w);
        end
        addr = addr + 16'd1;
      end
    endfunction

    function void check_write(xsb_wr_t w);
      xsb_wr_t e;
      if (expected_writes.size() == 0) begin
        $error("write beat with nothing expected: address %h mask %h last %b",
               w.write_address, w.xor_mask, w.last);
        errors++;
      end else begin
        e = expected_writes.pop_front();
        if (w.write_address !== e.write_address) begin
          $error("write_address: expected %h, got %h", e.write_address, w.write_address);
          errors++;
        end
        if (w.xor_mask !== e.xor_mask) begin
          $error("xor_mask: expected %h, got %h", e.xor_mask, w.xor_mask);
          errors++;
        end
        if (w.last !== e.last) begin
          $error("last: expected %b, got %b", e.last, w.last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        pos_valid;
  logic        pos_stall;
  xsb_pos_t    pos;
  logic        wr_valid;
  logic        wr_stall;
  xsb_wr_t     wr;
  logic        cfg_write;
  logic        cfg_index;
  logic [63:0] cfg_data;

  blit_scoreboard sb = new();
  bit             jitter;
  int             quiet;

  xor_sprite_blit_address_mask_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pos_valid (pos_valid),
    .pos_stall (pos_stall),
    .pos       (pos),
    .wr_valid  (wr_valid),
    .wr_stall  (wr_stall),
    .wr        (wr),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // beat monitor, predictor feed and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (cfg_write) begin
        sb.set_reg(cfg_index, cfg_data);
        quiet = 0;
      end
      if (pos_valid && !pos_stall) begin
        sb.add_sprite(pos);
        quiet = 0;
      end
      if (wr_valid && !wr_stall) begin
        sb.check_write(wr);
        quiet = 0;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall bursts
  initial begin
    wr_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (jitter && $urandom_range(0, 3) == 0) begin
        wr_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        wr_stall <= 1'b0;
      end
    end
  end

  task automatic send_pos(logic [7:0] x, logic [7:0] y);
    int gap;
    gap = (jitter && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      pos_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pos_valid   <= 1'b1;
    pos.pos_x   <= x;
    pos.pos_y   <= y;
    do @(posedge clk); while (pos_stall);
  endtask

  task automatic drain();
    pos_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] base, logic [63:0] pattern);
    drain();
    write_reg(REG_SCREEN_BASE, {48'd0, base});
    write_reg(REG_SPRITE_PATTERN, pattern);
  endtask

  initial begin
    logic [7:0] x;
    logic [7:0] y;
    rst       <= 1'b1;
    pos_valid <= 1'b0;
    pos       <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_SCREEN_BASE;
    cfg_data  <= '0;
    jitter    = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration, field extremes and y alignment
    send_pos(8'd0, 8'd0);
    send_pos(8'd255, 8'd255);
    send_pos(8'd7, 8'd0);
    send_pos(8'd1, 8'd7);
    send_pos(8'd8, 8'd8);
    send_pos(8'd0, 8'd7);
    send_pos(8'd255, 8'd0);
    send_pos(8'd0, 8'd255);
    send_pos(8'd3, 8'd4);
    send_pos(8'd128, 8'd64);

    // address wrap
    configure(16'hFFF8, '1);
    send_pos(8'd255, 8'd255);
    send_pos(8'd5, 8'd3);

    // zero masks
    configure(16'h0000, '0);
    send_pos(8'd0, 8'd0);
    send_pos(8'd9, 8'd1);

    configure(16'hFFFF, 64'h8000_0000_0000_0001);
    send_pos(8'd6, 8'd250);
    send_pos(8'd170, 8'd85);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        jitter = 1'b0;
      end
      if (ph == 2) begin
        configure(16'hFFFF, '1);
      end else begin
        configure(16'($urandom), {$urandom, $urandom});
      end
      for (int i = 0; i < 21; i++) begin
        x = 8'($urandom);
        y = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          x[2:0] = 3'd0;
        end
        if (ph < 4 && $urandom_range(0, 15) == 0) begin
          drain();
        end
        send_pos(x, y);
      end
    end

    pos_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
